[rtl/rkxbc_pkg.sv]
`default_nettype none

package rkxbc_pkg;

	localparam int KEY_BYTES   = 16;
	localparam int KEY_WORDS   = KEY_BYTES / 4;
	localparam int TWEAK_BYTES = 8;
	localparam int POS_W       = $clog2(KEY_BYTES);
	localparam int CFG_IDX_W   = $clog2(KEY_WORDS);
	localparam int CFG_DATA_W  = 32;
	localparam int ADDR_W      = 32;

	localparam logic [7:0] PASS_BYTE = 8'hFF;

	localparam logic [31:0] KEY_WORD_RESET [KEY_WORDS] = '{
		32'h16157E2B, 32'hA6D2AE28, 32'h8815F7AB, 32'h3C4FCF09
	};

	typedef logic [7:0]       byte_t;
	typedef logic [POS_W-1:0] pos_t;

	// register indexes on the config port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_WORD0 = 2'd0,
		CFG_KEY_WORD1 = 2'd1,
		CFG_KEY_WORD2 = 2'd2,
		CFG_KEY_WORD3 = 2'd3
	} cfg_reg_t;

	// tweak byte k: bits 4k+7..4k of the address, zero-filled above bit 31
	function automatic byte_t tweak_byte(input logic [ADDR_W-1:0] addr, input int k);
		logic [ADDR_W+7:0] wide;
		wide = {8'd0, addr} >> (4 * k);
		return wide[7:0];
	endfunction

	function automatic byte_t rotl1(input byte_t b);
		return {b[6:0], b[7]};
	endfunction

endpackage

`default_nettype wire

[rtl/rkxbc_if.sv]
`default_nettype none

// input beat: one data byte plus block marker and address
interface rkxbc_in_if;
	logic        valid;
	logic        ready;
	logic        block_start;
	logic [31:0] block_address;
	logic [7:0]  data_in;

	modport source (output valid, output block_start, output block_address,
		output data_in, input ready);
	modport sink (input valid, input block_start, input block_address,
		input data_in, output ready);
endinterface

// output beat: one transformed byte
interface rkxbc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;

	modport source (output valid, output data_out, input ready);
	modport sink (input valid, input data_out, output ready);
endinterface

`default_nettype wire

[rtl/rotating_key_xor_byte_cipher_top.sv]
`default_nettype none

// Rotating-key XOR byte cipher. One byte in, one byte out, in order; encrypt
// and decrypt are the same operation. A beat with block_start set reloads the
// 16-byte running key as base key XOR a tweak from block_address (key byte i
// uses address bits 4*(i%8)+7..4*(i%8)) and restarts the byte position at 0.
// A 0xFF byte passes through and does not rotate the key; any other byte is
// XORed with the key byte at the current position, which then rotates left
// by one. The position advances on every byte and wraps at 16.
// Throughput: one byte per cycle while the sink keeps up. The key lookup, XOR and
// rotate sit between the input beat and a single output register; input
// ready drops only while that output register holds a beat the sink has not
// taken. Base key writes (cfg_we/cfg_index/cfg_data) land in the base key
// only; the running key picks them up at the next block start. Reset loads
// the running key with the untweaked reset base key.
module rotating_key_xor_byte_cipher_top
	import rkxbc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	rkxbc_in_if.sink                   in_ch,
	rkxbc_out_if.source                out_ch
);

	logic [31:0] base_key_q [KEY_WORDS];
	byte_t       key_q      [KEY_BYTES];
	pos_t        pos_q;
	logic        out_valid_q;
	byte_t       data_out_s1;

	byte_t base_byte [KEY_BYTES];
	byte_t load_byte [KEY_BYTES];
	byte_t key_next  [KEY_BYTES];
	logic  in_beat;
	logic  pass;
	pos_t  cur_pos;
	byte_t cur_key;

	// base key viewed as bytes, and the tweaked reload value per byte
	always_comb begin
		for (int i = 0; i < KEY_BYTES; i++) begin
			base_byte[i] = base_key_q[i / 4][8 * (i % 4) +: 8];
			load_byte[i] = base_byte[i] ^ tweak_byte(in_ch.block_address, i % TWEAK_BYTES);
		end
	end

	// output register frees up when empty or being drained this cycle
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_beat     = in_ch.valid && in_ch.ready;
	assign pass        = (in_ch.data_in == PASS_BYTE);

	// on a block start the byte uses freshly loaded key byte 0
	assign cur_pos = in_ch.block_start ? '0 : pos_q;
	assign cur_key = in_ch.block_start ? load_byte[0] : key_q[pos_q];

	// next running key: reload on block start, then rotate the byte in use unless it is 0xFF
	always_comb begin
		for (int i = 0; i < KEY_BYTES; i++) begin
			key_next[i] = in_ch.block_start ? load_byte[i] : key_q[i];
		end
		if (!pass) begin
			key_next[cur_pos] = rotl1(cur_key);
		end
	end

	// base key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < KEY_WORDS; w++) begin
				base_key_q[w] <= KEY_WORD_RESET[w];
			end
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_KEY_WORD0: base_key_q[0] <= cfg_data;
				CFG_KEY_WORD1: base_key_q[1] <= cfg_data;
				CFG_KEY_WORD2: base_key_q[2] <= cfg_data;
				CFG_KEY_WORD3: base_key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// running key and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_BYTES; i++) begin
				key_q[i] <= KEY_WORD_RESET[i / 4][8 * (i % 4) +: 8];
			end
			pos_q <= '0;
		end else if (in_beat) begin
			for (int i = 0; i < KEY_BYTES; i++) begin
				key_q[i] <= key_next[i];
			end
			pos_q <= cur_pos + pos_t'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			out_valid_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			data_out_s1 <= pass ? in_ch.data_in : (in_ch.data_in ^ cur_key);
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.data_out = data_out_s1;

endmodule

`default_nettype wire
